FILE: rtl/tcc_pkg.sv
`timescale 1ns / 1ps

package tcc_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Pending-op queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Config port
  localparam int PADDR_W = 3;
  localparam logic REG_TEXT_COLOR = 1'b0;  // register index, paddr[2]
  localparam logic [7:0] COLOR_RESET = 8'h07;

  // Cell values
  localparam logic [15:0] RESET_CELL = 16'h0720;
  localparam logic [7:0]  CH_SPACE   = 8'h20;

  // Control bytes for put_char
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] TAB_MASK = 8'hF8;  // clears the low three bits

  // Command codes
  localparam logic [2:0] CMD_PUT_CHAR   = 3'd0;
  localparam logic [2:0] CMD_WRITE_CELL = 3'd1;
  localparam logic [2:0] CMD_READ_CELL  = 3'd2;
  localparam logic [2:0] CMD_SET_CURSOR = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;
  localparam logic [2:0] CMD_SET_PROT   = 3'd5;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [6:0] cell_col;
    logic [4:0] cell_row;
    logic [3:0] fore_color;
    logic [3:0] back_color;
  } tcc_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [10:0] cursor_position;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
    logic        scrolled;
  } tcc_out_t;

  // One classified command, handed from front to back
  typedef struct packed {
    logic        do_write;
    logic        do_read;
    logic        do_scroll;
    logic        do_clear;
    logic [4:0]  cell_row;
    logic [6:0]  cell_col;
    logic [15:0] wr_data;
    logic [4:0]  first_row;  // first row that moves in a scroll
    logic [4:0]  cur_row;
    logic [6:0]  cur_col;
    logic [10:0] cur_pos;
  } tcc_op_t;

endpackage

FILE: rtl/tcc_ram.sv
`timescale 1ns / 1ps

module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = tcc_pkg::COLUMNS_DEF * tcc_pkg::ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tcc_front.sv
`timescale 1ns / 1ps

module tcc_front #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcc_pkg::tcc_in_t in_data,
  input  logic [7:0]       text_color,
  input  logic             init_busy,
  input  logic             q_full,
  output logic             q_push,
  output tcc_pkg::tcc_op_t q_data
);

  localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);
  localparam logic [6:0] COL_LAST = 7'(COLUMNS - 1);

  logic [4:0] cur_row_r, cur_row_nxt;
  logic [6:0] cur_col_r, cur_col_nxt;
  logic [4:0] prot_r, prot_nxt;
  tcc_pkg::tcc_op_t op;

  assign in_stall = q_full || init_busy;
  assign q_push   = in_valid && !in_stall;
  assign q_data   = op;

  always_comb begin
    logic [7:0]  col_t;
    logic [5:0]  row_t;
    logic [4:0]  prot_t;
    logic [12:0] pos_t;
    logic        in_range;

    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    prot_nxt    = prot_r;
    op          = '0;
    col_t       = {1'b0, cur_col_r};
    row_t       = {1'b0, cur_row_r};
    prot_t      = ROW_LAST;
    in_range    = ({1'b0, in_data.cell_col} < 8'(COLUMNS)) &&
                  ({1'b0, in_data.cell_row} < 6'(ROWS));

    case (in_data.command)
      tcc_pkg::CMD_PUT_CHAR: begin
        case (in_data.char_code)
          tcc_pkg::CH_NL: begin
            col_t = '0;
            row_t = row_t + 6'd1;
          end
          tcc_pkg::CH_CR: begin
            col_t = '0;
          end
          tcc_pkg::CH_TAB: begin
            col_t = (col_t + 8'd8) & tcc_pkg::TAB_MASK;
          end
          tcc_pkg::CH_BS: begin
            if (col_t != 8'd0) begin
              col_t = col_t - 8'd1;
            end
          end
          default: begin
            op.do_write = 1'b1;
            op.cell_row = cur_row_r;
            op.cell_col = cur_col_r;
            op.wr_data  = {text_color, in_data.char_code};
            col_t       = col_t + 8'd1;
          end
        endcase
        // wrap at the right edge, scroll at the bottom
        if (col_t >= 8'(COLUMNS)) begin
          col_t = '0;
          row_t = row_t + 6'd1;
        end
        if (row_t >= 6'(ROWS)) begin
          row_t        = 6'(ROWS - 1);
          op.do_scroll = 1'b1;
        end
        cur_row_nxt = row_t[4:0];
        cur_col_nxt = col_t[6:0];
      end
      tcc_pkg::CMD_WRITE_CELL: begin
        op.do_write = in_range;
        op.cell_row = in_data.cell_row;
        op.cell_col = in_data.cell_col;
        op.wr_data  = {in_data.back_color, in_data.fore_color, in_data.char_code};
      end
      tcc_pkg::CMD_READ_CELL: begin
        op.do_read  = in_range;
        op.cell_row = in_data.cell_row;
        op.cell_col = in_data.cell_col;
      end
      tcc_pkg::CMD_SET_CURSOR: begin
        cur_col_nxt = ({1'b0, in_data.cell_col} < 8'(COLUMNS)) ? in_data.cell_col : COL_LAST;
        cur_row_nxt = ({1'b0, in_data.cell_row} < 6'(ROWS)) ? in_data.cell_row : ROW_LAST;
      end
      tcc_pkg::CMD_CLEAR: begin
        op.do_clear = 1'b1;
        cur_row_nxt = '0;
        cur_col_nxt = '0;
        prot_nxt    = '0;
      end
      tcc_pkg::CMD_SET_PROT: begin
        if ({1'b0, in_data.cell_row} < 6'(ROWS)) begin
          prot_t = in_data.cell_row;
        end
        prot_nxt = prot_t;
        if (cur_row_r < prot_t) begin
          cur_row_nxt = prot_t;
          cur_col_nxt = '0;
        end
      end
      default: begin
      end
    endcase

    pos_t        = 13'(cur_row_nxt) * 13'(COLUMNS) + 13'(cur_col_nxt);
    op.first_row = prot_r;
    op.cur_row   = cur_row_nxt;
    op.cur_col   = cur_col_nxt;
    op.cur_pos   = pos_t[10:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      prot_r    <= '0;
    end else if (q_push) begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      prot_r    <= prot_nxt;
    end
  end

  a_row_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_row_r} < 6'(ROWS))
    else $error("cursor row left the screen");

  a_col_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_col_r} < 8'(COLUMNS))
    else $error("cursor column left the screen");

  a_prot_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, prot_r} < 6'(ROWS))
    else $error("protected row count out of range");

endmodule

FILE: rtl/tcc_queue.sv
`timescale 1ns / 1ps

module tcc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tcc_pkg::tcc_op_t push_data,
  output logic             full,
  input  logic             pop,
  output tcc_pkg::tcc_op_t pop_data,
  output logic             empty
);

  localparam int DEPTH = tcc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcc_pkg::tcc_op_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/tcc_back.sv
`timescale 1ns / 1ps

module tcc_back #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_pop,
  input  tcc_pkg::tcc_op_t  q_data,
  input  logic [7:0]        text_color,
  output logic              init_busy,
  output logic              out_valid,
  input  logic              out_stall,
  output tcc_pkg::tcc_out_t out_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam logic [IDX_W-1:0] LAST_BASE = IDX_W'((ROWS - 1) * COLUMNS);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CELL_COUNT - 1);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_BLANK  = 3'd5;
  localparam logic [2:0] ST_CLEAR  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  tcc_pkg::tcc_op_t  cur_r, cur_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  wdst_r, wdst_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcc_pkg::tcc_out_t out_r, out_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;
  logic [15:0]       blank;
  logic [12:0]       cell_lin, first_lin;
  logic [IDX_W-1:0]  cell_addr;
  logic              out_free, out_load, use_rd;

  tcc_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign blank     = {text_color, tcc_pkg::CH_SPACE};
  assign cell_lin  = 13'(cur_r.cell_row) * 13'(COLUMNS) + 13'(cur_r.cell_col);
  assign first_lin = 13'(cur_r.first_row) * 13'(COLUMNS);
  assign cell_addr = cell_lin[IDX_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty && out_free;
  assign init_busy = (state_r == ST_INIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    wdst_nxt  = wdst_r;
    pend_nxt  = pend_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = blank;
    ram_raddr = cell_addr;
    out_load  = 1'b0;
    use_rd    = 1'b0;

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcc_pkg::RESET_CELL;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          cur_nxt   = q_data;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cur_r.do_write) begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr;
          ram_wdata = cur_r.wr_data;
        end
        if (cur_r.do_read) begin
          state_nxt = ST_READ;
        end else if (cur_r.do_clear) begin
          idx_nxt   = '0;
          state_nxt = ST_CLEAR;
        end else if (cur_r.do_scroll) begin
          idx_nxt   = first_lin[IDX_W-1:0];
          pend_nxt  = 1'b0;
          state_nxt = ST_SCROLL;
        end else begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        out_load  = 1'b1;
        use_rd    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one row below, write the previous read's registered data one row up
        ram_we    = pend_r;
        ram_waddr = wdst_r;
        ram_wdata = ram_rdata;
        if (idx_r < LAST_BASE) begin
          ram_raddr = idx_r + IDX_W'(COLUMNS);
          pend_nxt  = 1'b1;
          wdst_nxt  = idx_r;
          idx_nxt   = idx_r + IDX_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK, ST_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt.read_data       = use_rd ? ram_rdata : 16'd0;
    out_nxt.cursor_position = cur_r.cur_pos;
    out_nxt.cursor_row_out  = cur_r.cur_row;
    out_nxt.cursor_col_out  = cur_r.cur_col;
    out_nxt.scrolled        = cur_r.do_scroll;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    wdst_r <= wdst_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !out_valid_r)
    else $error("result shown during the power-up fill");

  a_blank_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BLANK) |-> (idx_r >= LAST_BASE))
    else $error("scroll blanking outside the last row");

  a_scroll_dest: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCROLL) && pend_r) |-> (wdst_r < LAST_BASE))
    else $error("scroll copy writes into the last row");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("result not posted on completion");

endmodule

FILE: rtl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake                     Payload
// -------  ---  ----------------------------  ----------------------------------
// in       in   in_valid / in_stall           in_data  (tcc_in_t, one command)
// out      out  out_valid / out_stall         out_data (tcc_out_t, one result)
// cfg      in   psel/penable/pwrite, pready=1 paddr/pwdata/prdata, text_color @0
//
// Flow: the front takes one item a cycle into a 2-deep queue while in_stall is low; the
//   back, bound by the single write port of the screen RAM, finishes each item before it
//   takes the next; clear walks every cell, a scrolling put_char the unprotected rows.
// Reset: a fill pass writes 0x0720 to all CELL_COUNT cells;
//   in_stall stays high meanwhile, config writes are still taken.
// Stalls: a waiting result sits in the output register while the front keeps queuing.

module text_console_cursor_scroll #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tcc_pkg::tcc_in_t            in_data,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output tcc_pkg::tcc_out_t           out_data,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [7:0]       text_color_r;
  logic             init_busy;
  logic             q_full, q_empty, q_push, q_pop;
  tcc_pkg::tcc_op_t q_wdata, q_rdata;

  // text_color register, word at byte address 0
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcc_pkg::COLOR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == tcc_pkg::REG_TEXT_COLOR)) begin
      text_color_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == tcc_pkg::REG_TEXT_COLOR) ? {24'd0, text_color_r} : 32'd0;

  // front: owns cursor and protected count, turns each command into a RAM job
  tcc_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .text_color (text_color_r),
    .init_busy  (init_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // jobs wait here in command order
  tcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: screen RAM, write/read, scroll copy, clear and power-up fill
  tcc_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .text_color (text_color_r),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcc_pkg::*;

  localparam int NCOL = COLUMNS_DEF;
  localparam int NROW = ROWS_DEF;
  localparam int NCELL = NCOL * NROW;

  // Unused command codes: the block reports the cursor and changes nothing
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam logic [PADDR_W-1:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};

  // Quiet margin after the last result before the next register write
  localparam int SETTLE = NCELL + 2 * NCOL + 16;
  // Reset fill, ~100 full-screen scrolls, clears and stalled items, taken several times
  localparam int LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_stall;
  tcc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tcc_out_t out_data;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  text_console_cursor_scroll #(
    .COLUMNS(NCOL),
    .ROWS   (NROW)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Console model: screen contents, cursor, protected rows and current attribute.
  // Updated once per accepted command item; every command yields one result.
  // ---------------------------------------------------------------------------
  logic [15:0] screen_mem [0:NCELL-1];
  int          crow;
  int          ccol;
  int          prot_rows;
  logic [7:0]  text_attr;

  tcc_in_t  cmd_backlog[$];      // commands waiting for the driver
  tcc_out_t pending_results[$];  // predicted results, oldest first

  int cmds_posted = 0;
  int results_seen = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int idle_pct = 0;    // chance in percent of a gap / stall burst; 0 = none
  int gap_left = 0;
  int stall_left = 0;

  task automatic console_apply(input tcc_in_t c);
    tcc_out_t    r;
    logic [15:0] rd;
    logic        scr;
    int          col;
    int          row;
    int          i;
    rd = '0;
    scr = 1'b0;
    col = c.cell_col;
    row = c.cell_row;
    case (c.command)
      CMD_PUT_CHAR: begin
        case (c.char_code)
          CH_NL: begin
            ccol = 0;
            crow++;
          end
          CH_CR: ccol = 0;
          CH_TAB: ccol = (ccol + 8) & ~7;
          CH_BS: if (ccol > 0) ccol--;
          default: begin
            screen_mem[crow * NCOL + ccol] = {text_attr, c.char_code};
            ccol++;
          end
        endcase
        if (ccol >= NCOL) begin
          ccol = 0;
          crow++;
        end
        // past the bottom: rows from the protected count up move one row up
        if (crow >= NROW) begin
          for (i = prot_rows * NCOL; i < (NROW - 1) * NCOL; i++)
            screen_mem[i] = screen_mem[i + NCOL];
          for (i = (NROW - 1) * NCOL; i < NCELL; i++)
            screen_mem[i] = {text_attr, CH_SPACE};
          crow = NROW - 1;
          scr = 1'b1;
        end
      end
      CMD_WRITE_CELL: begin
        if (col < NCOL && row < NROW)
          screen_mem[row * NCOL + col] = {c.back_color, c.fore_color, c.char_code};
      end
      CMD_READ_CELL: begin
        if (col < NCOL && row < NROW) rd = screen_mem[row * NCOL + col];
      end
      CMD_SET_CURSOR: begin
        ccol = (col < NCOL) ? col : NCOL - 1;
        crow = (row < NROW) ? row : NROW - 1;
      end
      CMD_CLEAR: begin
        for (i = 0; i < NCELL; i++) screen_mem[i] = {text_attr, CH_SPACE};
        prot_rows = 0;
        crow = 0;
        ccol = 0;
      end
      CMD_SET_PROT: begin
        prot_rows = (row < NROW) ? row : NROW - 1;
        // cursor inside the protected band is pushed just below it
        if (crow < prot_rows) begin
          crow = prot_rows;
          ccol = 0;
        end
      end
      default: ;
    endcase
    r.read_data = rd;
    r.cursor_position = 11'(crow * NCOL + ccol);
    r.cursor_row_out = 5'(crow);
    r.cursor_col_out = 7'(ccol);
    r.scrolled = scr;
    pending_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Command driver. The item on in_data is predicted at the edge that takes it,
  // then the next one is presented or a short gap is inserted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      console_apply(in_data);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 3);
      end else if (cmd_backlog.size() > 0) begin
        in_data <= cmd_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() > 0) begin
        in_data <= cmd_backlog.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each taken result is checked against the oldest prediction.
  // Also throws random stall bursts at the output.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_mon
    tcc_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: result with nothing pending: rd=%h pos=%0d row=%0d col=%0d scr=%b",
                     out_data.read_data, out_data.cursor_position, out_data.cursor_row_out,
                     out_data.cursor_col_out, out_data.scrolled);
        end else begin
          want = pending_results.pop_front();
          if (out_data !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("ERROR: result %0d: exp rd=%h pos=%0d row=%0d col=%0d scr=%b",
                       results_seen, want.read_data, want.cursor_position,
                       want.cursor_row_out, want.cursor_col_out, want.scrolled);
              $display("       got rd=%h pos=%0d row=%0d col=%0d scr=%b",
                       out_data.read_data, out_data.cursor_position, out_data.cursor_row_out,
                       out_data.cursor_col_out, out_data.scrolled);
            end
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic post(input logic [2:0] op, input logic [7:0] ch, input logic [6:0] col,
                      input logic [4:0] row, input logic [3:0] fg, input logic [3:0] bg);
    tcc_in_t c;
    c.command = op;
    c.char_code = ch;
    c.cell_col = col;
    c.cell_row = row;
    c.fore_color = fg;
    c.back_color = bg;
    cmd_backlog.push_back(c);
    cmds_posted++;
  endtask

  // Wait for every predicted result, then let any trailing clear or scroll finish
  task automatic drain();
    while (results_seen != cmds_posted) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Two-phase register write; the model follows at the write edge
  task automatic set_text_color(input logic [7:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_TEXT_COLOR;
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    text_attr = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Mostly in-range coordinates, sometimes anything the field allows
  function automatic logic [6:0] pick_col();
    return ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, NCOL - 1))
                                      : 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [4:0] pick_row();
    return ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, NROW - 1))
                                      : 5'($urandom_range(0, 31));
  endfunction

  // Filler for fields a command ignores, or any value a field allows
  function automatic logic [7:0] any_ch();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [6:0] any_col();
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [4:0] any_row();
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [3:0] any_nib();
    return 4'($urandom_range(0, 15));
  endfunction

  // One short burst of related commands. Clear walks the whole screen and scroll the
  // unprotected rows, so both are kept rare; text runs and cell traffic are the bulk.
  task automatic queue_burst();
    int          kind;
    int          n;
    int          k;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [7:0]  ch;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // text run with the odd control byte
      n = $urandom_range(1, 12);
      repeat (n) begin
        k = $urandom_range(0, 39);
        case (k)
          0: ch = CH_NL;
          1: ch = CH_CR;
          2: ch = CH_TAB;
          3: ch = CH_BS;
          default: ch = any_ch();
        endcase
        post(CMD_PUT_CHAR, ch, any_col(), any_row(), any_nib(), any_nib());
      end
    end else if (kind < 55) begin
      // cell write, read back half the time
      col = pick_col();
      row = pick_row();
      post(CMD_WRITE_CELL, any_ch(), col, row, any_nib(), any_nib());
      if ($urandom_range(0, 1))
        post(CMD_READ_CELL, any_ch(), col, row, any_nib(), any_nib());
    end else if (kind < 65) begin
      post(CMD_SET_CURSOR, any_ch(), pick_col(), pick_row(), any_nib(), any_nib());
    end else if (kind < 72) begin
      // park near the bottom right, then push past it
      post(CMD_SET_CURSOR, any_ch(), 7'($urandom_range(NCOL - 10, 127)),
           5'($urandom_range(NROW - 3, 31)), any_nib(), any_nib());
      n = $urandom_range(1, 4);
      repeat (n) begin
        k = $urandom_range(0, 3);
        ch = (k == 0) ? CH_NL : (k == 1) ? CH_TAB : any_ch();
        post(CMD_PUT_CHAR, ch, any_col(), any_row(), any_nib(), any_nib());
      end
    end else if (kind < 80) begin
      row = $urandom_range(0, 1) ? 5'($urandom_range(0, 4)) : any_row();
      post(CMD_SET_PROT, any_ch(), any_col(), row, any_nib(), any_nib());
    end else if (kind < 82) begin
      post(CMD_CLEAR, any_ch(), any_col(), any_row(), any_nib(), any_nib());
    end else if (kind < 84) begin
      post($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B, any_ch(),
           any_col(), any_row(), any_nib(), any_nib());
    end else begin
      post(CMD_READ_CELL, any_ch(), pick_col(), pick_row(), any_nib(), any_nib());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed checks at the reset attribute, then random phases,
  // each at its own attribute and idle rate. The last phase runs without idling.
  // Between phases the sender waits until every result is back.
  // ---------------------------------------------------------------------------
  initial begin : run
    logic [7:0] phase_attr [5];
    int         phase_idle [5];
    int         phase_len  [5];
    int         p;
    int         target;

    for (int i = 0; i < NCELL; i++) screen_mem[i] = RESET_CELL;
    crow = 0;
    ccol = 0;
    prot_rows = 0;
    text_attr = COLOR_RESET;

    phase_attr = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h1E,
                   8'($urandom_range(0, 255))};
    phase_idle = '{25, 0, 40, 15, 0};
    phase_len  = '{450, 400, 450, 400, 300};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset attribute; the block holds off input during its fill pass
    idle_pct = 20;
    post(CMD_READ_CELL,  8'h00, 7'd0,   5'd0,  4'd0,  4'd0);   // reset cell value
    post(CMD_READ_CELL,  8'hFF, 7'd127, 5'd31, 4'd15, 4'd15);  // far out of range
    post(CMD_PUT_CHAR,   8'h41, 7'd0,   5'd0,  4'd0,  4'd0);
    post(CMD_PUT_CHAR,   8'hFF, 7'd0,   5'd0,  4'd0,  4'd0);
    post(CMD_PUT_CHAR,   CH_TAB, 7'd0,  5'd0,  4'd0,  4'd0);
    post(CMD_PUT_CHAR,   CH_BS, 7'd0,   5'd0,  4'd0,  4'd0);
    post(CMD_PUT_CHAR,   CH_CR, 7'd0,   5'd0,  4'd0,  4'd0);
    post(CMD_PUT_CHAR,   CH_BS, 7'd0,   5'd0,  4'd0,  4'd0);   // backspace at column 0
    post(CMD_PUT_CHAR,   CH_NL, 7'd0,   5'd0,  4'd0,  4'd0);
    post(CMD_PUT_CHAR,   8'h00, 7'd0,   5'd0,  4'd0,  4'd0);   // NUL is a plain glyph
    post(CMD_WRITE_CELL, 8'hFF, 7'(NCOL - 1), 5'(NROW - 1), 4'd15, 4'd15);
    post(CMD_WRITE_CELL, 8'h55, 7'(NCOL), 5'd0,  4'd3,  4'd5); // column out of range
    post(CMD_WRITE_CELL, 8'hAA, 7'd0, 5'(NROW),  4'd5,  4'd3); // row out of range
    post(CMD_WRITE_CELL, 8'h11, 7'd127, 5'd31, 4'd1,  4'd1);
    post(CMD_READ_CELL,  8'h00, 7'(NCOL - 1), 5'(NROW - 1), 4'd0, 4'd0);
    post(CMD_READ_CELL,  8'h00, 7'd0,   5'd0,  4'd0,  4'd0);
    post(CMD_SET_CURSOR, 8'h00, 7'd127, 5'd31, 4'd0,  4'd0);   // clamped to bottom right
    post(CMD_PUT_CHAR,   8'h5A, 7'd0,   5'd0,  4'd0,  4'd0);   // wrap and scroll
    post(CMD_SET_PROT,   8'h00, 7'd0,   5'd31, 4'd0,  4'd0);   // clamped count
    post(CMD_SET_CURSOR, 8'h00, 7'(NCOL - 8), 5'(NROW - 1), 4'd0, 4'd0);
    post(CMD_PUT_CHAR,   CH_TAB, 7'd0,  5'd0,  4'd0,  4'd0);   // scroll, nothing moves
    post(CMD_SET_CURSOR, 8'h00, 7'd10,  5'd2,  4'd0,  4'd0);
    post(CMD_SET_PROT,   8'h00, 7'd0,   5'd5,  4'd0,  4'd0);   // cursor pushed down
    post(CMD_SET_CURSOR, 8'h00, 7'd0,   5'(NROW - 1), 4'd0, 4'd0);
    post(CMD_PUT_CHAR,   CH_NL, 7'd0,   5'd0,  4'd0,  4'd0);   // scroll below band
    post(CMD_READ_CELL,  8'h00, 7'd0,   5'd0,  4'd0,  4'd0);
    post(CMD_SPARE_A,    8'hFF, 7'd127, 5'd31, 4'd15, 4'd15);
    post(CMD_SPARE_B,    8'hFF, 7'd127, 5'd31, 4'd15, 4'd15);
    post(CMD_CLEAR,      8'h00, 7'd0,   5'd0,  4'd0,  4'd0);
    post(CMD_READ_CELL,  8'h00, 7'(NCOL - 1), 5'(NROW - 1), 4'd0, 4'd0);

    for (p = 0; p < 5; p++) begin
      drain();
      set_text_color(phase_attr[p]);
      idle_pct = phase_idle[p];
      target = cmds_posted + phase_len[p];
      while (cmds_posted < target) queue_burst();
    end

    drain();
    err_cnt += pending_results.size();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
